FILE: design/fspl_pkg.sv
// ----------------------------------------------------------------------------
// fspl_pkg: shared definitions of the forward speed loop
// Constants, microcode word layout, operation codes and the control program.
// ----------------------------------------------------------------------------
package fspl_pkg;

  // Encoder history: the window spans WINDOW ticks, so WINDOW+1 angles are kept.
  localparam int unsigned WINDOW     = 4;
  localparam int unsigned HIST_DEPTH = WINDOW + 1;

  // Drive saturation, Q8.8 plus or minus 100.0.
  localparam logic signed [15:0] DRIVE_MAX = 16'sd25600;
  localparam logic signed [15:0] DRIVE_MIN = -16'sd25600;

  // Configuration registers.
  localparam int unsigned      CFG_IDX_W       = 2;
  localparam logic [1:0]       CFG_GAIN        = 2'd0;
  localparam logic [1:0]       CFG_SPEED_SCALE = 2'd1;
  localparam logic [15:0]      GAIN_RESET      = 16'd197;
  localparam logic [15:0]      SCALE_RESET     = 16'd1778;

  // Microcode step counter.
  localparam int unsigned PC_W = 4;

  localparam logic [PC_W-1:0] STEP_LOAD   = 4'd0;
  localparam logic [PC_W-1:0] STEP_DIFF_L = 4'd1;
  localparam logic [PC_W-1:0] STEP_DIFF_R = 4'd2;
  localparam logic [PC_W-1:0] STEP_SUM    = 4'd3;
  localparam logic [PC_W-1:0] STEP_MUL_SC = 4'd4;
  localparam logic [PC_W-1:0] STEP_ERR    = 4'd5;
  localparam logic [PC_W-1:0] STEP_MUL_GN = 4'd6;
  localparam logic [PC_W-1:0] STEP_ROUND  = 4'd7;
  localparam logic [PC_W-1:0] STEP_DRIVE  = 4'd8;

  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_LOAD      = 4'd1,
    OP_DIFF_L    = 4'd2,
    OP_DIFF_R    = 4'd3,
    OP_SUM       = 4'd4,
    OP_MUL_SCALE = 4'd5,
    OP_ERR       = 4'd6,
    OP_MUL_GAIN  = 4'd7,
    OP_ROUND     = 4'd8,
    OP_DRIVE     = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    COND_ALWAYS   = 2'd0,
    COND_IN_VALID = 2'd1,
    COND_OUT_FREE = 2'd2
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic            jump;
    logic [PC_W-1:0] dest;
  } uword_t;

  // Control program. A step whose condition is not met holds its place;
  // otherwise it advances, or jumps to dest when jump is set.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, jump: 1'b1, dest: STEP_LOAD};
    case (pc)
      STEP_LOAD:   w = '{op: OP_LOAD,      cond: COND_IN_VALID, jump: 1'b0, dest: STEP_LOAD};
      STEP_DIFF_L: w = '{op: OP_DIFF_L,    cond: COND_ALWAYS,   jump: 1'b0, dest: STEP_LOAD};
      STEP_DIFF_R: w = '{op: OP_DIFF_R,    cond: COND_ALWAYS,   jump: 1'b0, dest: STEP_LOAD};
      STEP_SUM:    w = '{op: OP_SUM,       cond: COND_ALWAYS,   jump: 1'b0, dest: STEP_LOAD};
      STEP_MUL_SC: w = '{op: OP_MUL_SCALE, cond: COND_ALWAYS,   jump: 1'b0, dest: STEP_LOAD};
      STEP_ERR:    w = '{op: OP_ERR,       cond: COND_ALWAYS,   jump: 1'b0, dest: STEP_LOAD};
      STEP_MUL_GN: w = '{op: OP_MUL_GAIN,  cond: COND_ALWAYS,   jump: 1'b0, dest: STEP_LOAD};
      STEP_ROUND:  w = '{op: OP_ROUND,     cond: COND_ALWAYS,   jump: 1'b0, dest: STEP_LOAD};
      STEP_DRIVE:  w = '{op: OP_DRIVE,     cond: COND_OUT_FREE, jump: 1'b1, dest: STEP_LOAD};
      default:     w = '{op: OP_NOP,       cond: COND_ALWAYS,   jump: 1'b1, dest: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

FILE: design/forward_speed_pi_loop.sv
// ----------------------------------------------------------------------------
// forward_speed_pi_loop: incremental proportional forward speed controller
// Microcoded sequencer over a shared multiply and add datapath.
// ----------------------------------------------------------------------------
// Each item is one control tick: a target speed (Q8.8) and the left and right
// wheel encoder angles. The block keeps the last WINDOW+1 angles of each
// wheel, measures speed as the summed angle change over WINDOW ticks times
// speed_scale, and adds gain times the speed error to a running drive value,
// clamped to plus or minus 100.0. A new target reloads the drive value first.
// The program has nine steps. The load step takes the item, and the eight
// steps after it compute the update, the last of them writing the result to
// the output register. The steps share a single multiplier, and the block
// takes no new item until the last step has run for the current one. A
// result waiting in the output register does not hold off the next item,
// but the last step waits while the previous result is still stalled.
// Configuration writes should only be made while idle.
module forward_speed_pi_loop (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [fspl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [15:0]                      cfg_data_i,
  // input items
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [15:0]               target_speed_i,
  input  logic signed [31:0]               left_count_i,
  input  logic signed [31:0]               right_count_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [15:0]               drive_o
);
  import fspl_pkg::*;

  // Configuration registers.
  logic [15:0] gain_q, scale_q;

  // Sequencer.
  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            cond_ok;
  op_e             dp_op;

  // Controller state.
  logic signed [31:0] left_hist_q  [HIST_DEPTH];
  logic signed [31:0] right_hist_q [HIST_DEPTH];
  logic signed [15:0] held_q;
  logic signed [15:0] drive_q;
  logic signed [15:0] target_q;

  // Output register.
  logic               out_valid_q;
  logic signed [15:0] out_drive_q;

  logic               in_accept;
  logic               out_free;
  logic               drive_load;
  logic signed [15:0] drive_sat;

  // The current control word is fetched combinationally from the program.
  assign uw = ucode_rom(pc_q);

  // Input is taken only at the load step; the output slot counts as free
  // when empty or being drained in this cycle.
  assign in_stall_o = (uw.cond != COND_IN_VALID);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:   cond_ok = 1'b1;
      COND_IN_VALID: cond_ok = in_valid_i;
      COND_OUT_FREE: cond_ok = out_free;
      default:       cond_ok = 1'b1;
    endcase
  end

  // A step that is not ready holds its place; otherwise it advances or jumps.
  always_comb begin
    if (!cond_ok) begin
      pc_d = pc_q;
    end else if (uw.jump) begin
      pc_d = uw.dest;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  assign dp_op      = cond_ok ? uw.op : OP_NOP;
  assign drive_load = (dp_op == OP_DRIVE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

  // Configuration port; indexes beyond the two registers are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RESET;
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_GAIN) begin
        gain_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_SPEED_SCALE) begin
        scale_q <= cfg_data_i;
      end
    end
  end

  // Encoder histories shift on every accepted item, newest at entry zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        left_hist_q[i]  <= '0;
        right_hist_q[i] <= '0;
      end
    end else if (in_accept) begin
      left_hist_q[0]  <= left_count_i;
      right_hist_q[0] <= right_count_i;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        left_hist_q[i]  <= left_hist_q[i-1];
        right_hist_q[i] <= right_hist_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      target_q <= target_speed_i;
    end
  end

  // A changed target reloads the running drive value; the last step of the
  // program writes back the clamped update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      drive_q <= '0;
    end else if (in_accept) begin
      if (target_speed_i != held_q) begin
        held_q  <= target_speed_i;
        drive_q <= target_speed_i;
      end
    end else if (drive_load) begin
      drive_q <= drive_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (drive_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drive_load) begin
      out_drive_q <= drive_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = out_drive_q;

  fspl_dp u_dp (
    .clk_i       (clk_i),
    .op_i        (dp_op),
    .left_new_i  (left_hist_q[0]),
    .left_old_i  (left_hist_q[WINDOW]),
    .right_new_i (right_hist_q[0]),
    .right_old_i (right_hist_q[WINDOW]),
    .target_i    (target_q),
    .drive_i     (drive_q),
    .gain_i      (gain_q),
    .scale_i     (scale_q),
    .drive_sat_o (drive_sat)
  );

  // Only one item is in flight: an accepted item moves the program off the
  // load step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (pc_q == STEP_DIFF_L))
    else $error("sequencer did not start after an accepted item");

  // The step counter never leaves the program.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= STEP_DRIVE)
    else $error("step counter outside the control program");

  // A finished drive update always shows up as a valid result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_load |=> (out_valid_o && (drive_o == drive_q)))
    else $error("result register not loaded with the new drive value");

  // The written-back drive value stays within its limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_load |=> (drive_q <= DRIVE_MAX && drive_q >= DRIVE_MIN))
    else $error("drive value outside saturation limits");

  // The last step never overwrites a result that is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !drive_load)
    else $error("stalled result overwritten");

endmodule

FILE: design/fspl_dp.sv
// ----------------------------------------------------------------------------
// fspl_dp: arithmetic datapath of the forward speed loop
// Accumulator, difference and product registers around one shared multiplier.
// ----------------------------------------------------------------------------
module fspl_dp (
  input  logic                      clk_i,
  input  fspl_pkg::op_e             op_i,
  input  logic signed [31:0]        left_new_i,
  input  logic signed [31:0]        left_old_i,
  input  logic signed [31:0]        right_new_i,
  input  logic signed [31:0]        right_old_i,
  input  logic signed [15:0]        target_i,
  input  logic signed [15:0]        drive_i,
  input  logic        [15:0]        gain_i,
  input  logic        [15:0]        scale_i,
  output logic signed [15:0]        drive_sat_o
);
  import fspl_pkg::*;

  logic signed [33:0] acc_q, acc_d;
  logic signed [32:0] dif_q, dif_d;
  logic signed [49:0] prod_q, prod_d;

  logic signed [16:0] mul_b;
  logic signed [50:0] mul_p;
  logic signed [50:0] err_full;
  logic signed [31:0] err_sat;
  logic signed [50:0] rnd_sum;
  logic signed [34:0] drv_sum;

  // One multiplier serves both the speed scaling and the gain step.
  assign mul_b = (op_i == OP_MUL_GAIN) ? $signed({1'b0, gain_i}) : $signed({1'b0, scale_i});
  assign mul_p = acc_q * mul_b;

  // Speed error, saturated to the signed 32-bit range.
  assign err_full = $signed({{35{target_i[15]}}, target_i}) - $signed({prod_q[49], prod_q});
  always_comb begin
    if (err_full > 51'sd2147483647) begin
      err_sat = 32'sh7fffffff;
    end else if (err_full < -51'sd2147483648) begin
      err_sat = 32'sh80000000;
    end else begin
      err_sat = err_full[31:0];
    end
  end

  // Round Q8.24 to Q8.8, half up; the bit select is a floor shift.
  assign rnd_sum = $signed({prod_q[49], prod_q}) + 51'sd32768;

  always_comb begin
    acc_d  = acc_q;
    dif_d  = dif_q;
    prod_d = prod_q;
    case (op_i)
      OP_DIFF_L:    acc_d  = {{2{left_new_i[31]}}, left_new_i} - {{2{left_old_i[31]}}, left_old_i};
      OP_DIFF_R:    dif_d  = {right_new_i[31], right_new_i} - {right_old_i[31], right_old_i};
      OP_SUM:       acc_d  = acc_q + {dif_q[32], dif_q};
      OP_MUL_SCALE: prod_d = mul_p[49:0];
      OP_ERR:       acc_d  = {{2{err_sat[31]}}, err_sat};
      OP_MUL_GAIN:  prod_d = mul_p[49:0];
      OP_ROUND:     acc_d  = rnd_sum[49:16];
      default:      acc_d  = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    dif_q  <= dif_d;
    prod_q <= prod_d;
  end

  // New drive value: running value plus increment, clamped.
  assign drv_sum = {{19{drive_i[15]}}, drive_i} + {acc_q[33], acc_q};
  always_comb begin
    if (drv_sum > 35'sd25600) begin
      drive_sat_o = DRIVE_MAX;
    end else if (drv_sum < -35'sd25600) begin
      drive_sat_o = DRIVE_MIN;
    end else begin
      drive_sat_o = drv_sum[15:0];
    end
  end

endmodule
